### design/ded_pkg.sv
// ----------------------------------------------------------------------------
// ded_pkg
// Shared widths, constants and control types of the descriptor distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package ded_pkg;

   localparam int ELEMENT_WIDTH = 16;
   localparam int LENGTH_WIDTH  = 10;
   localparam int MAX_LENGTH    = 512;
   localparam int LENGTH_RESET  = 352;
   localparam int SQUARE_WIDTH  = 2 * ELEMENT_WIDTH;
   localparam int SUM_WIDTH     = 41;
   localparam int DIST_WIDTH    = 21;
   // The radicand is padded to an even width so that it splits into bit pairs.
   localparam int RAD_WIDTH     = 2 * DIST_WIDTH;
   localparam int REM_WIDTH     = DIST_WIDTH + 3;
   localparam int ROOT_STEPS    = DIST_WIDTH;
   localparam int ITER_WIDTH    = $clog2(ROOT_STEPS);

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_ROOT,
      ST_HOLD
   } ded_state_type;

   typedef struct packed {
      logic capture;
      logic accumulate;
      logic start;
      logic iterate;
      logic publish;
   } ded_cmd_type;

   typedef struct packed {
      logic last;
   } ded_status_type;

endpackage

`default_nettype wire

### design/ded_channels.sv
// ----------------------------------------------------------------------------
// ded_channels
// Valid/ready channel interfaces for element pairs and distance results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ded_req_if;
   logic                               valid;
   logic                               ready;
   logic [ded_pkg::ELEMENT_WIDTH-1:0] first_element;
   logic [ded_pkg::ELEMENT_WIDTH-1:0] second_element;

   modport source (output valid, output first_element, output second_element, input ready);
   modport sink   (input valid, input first_element, input second_element, output ready);
endinterface

interface ded_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ded_pkg::DIST_WIDTH-1:0] distance;
   logic [ded_pkg::SUM_WIDTH-1:0]  squared_sum;

   modport source (output valid, output distance, output squared_sum, input ready);
   modport sink   (input valid, input distance, input squared_sum, output ready);
endinterface

`default_nettype wire

### design/descriptor_euclidean_distance.sv
// ----------------------------------------------------------------------------
// descriptor_euclidean_distance
// Euclidean distance between two streamed descriptors.
// ----------------------------------------------------------------------------
// Each transaction on req_ch carries one element pair (unsigned Q8.8). The
// block squares the difference, adds it to a saturating 41-bit sum and counts
// pairs. When the count reaches the configured length (csr_write_data, written
// with csr_write_enable; a length of zero acts as one, above 512 as 512), one
// transaction on rsp_ch carries the floor square root and the raw sum.
// Element pairs are taken one per cycle, save that a pair closing a descriptor
// can be held off. The square is registered when the closing pair is accepted;
// the sum is then accumulated and captured as the radicand, 21 iterations of a
// two-bit-per-cycle square root follow, and the root goes into the output
// register. The root unit handles one descriptor at a time, so the pair that
// closes the next descriptor waits until the root unit is free again. Pairs
// that do not close a descriptor keep flowing while the root runs. If rsp_ch
// stalls, the finished root waits in the unit and the next closing pair is
// held off. Reset clears the sum, the count and the result channel, and sets
// the length to 352.
// ----------------------------------------------------------------------------
`default_nettype none

module descriptor_euclidean_distance (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [ded_pkg::LENGTH_WIDTH-1:0] csr_write_data,
   ded_req_if.sink                                req_ch,
   ded_rsp_if.source                              rsp_ch
);

   ded_pkg::ded_cmd_type    cmd;
   ded_pkg::ded_status_type status;
   logic                    req_ready;
   logic                    rsp_valid;

   ded_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ded_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .first_element    (req_ch.first_element),
      .second_element   (req_ch.second_element),
      .cmd              (cmd),
      .status           (status),
      .distance         (rsp_ch.distance),
      .squared_sum      (rsp_ch.squared_sum)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

endmodule

`default_nettype wire

### design/ded_datapath.sv
// ----------------------------------------------------------------------------
// ded_datapath
// Squaring stage, saturating accumulator, element counter, length register,
// binary (bit-pair) restoring square root and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ded_datapath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [ded_pkg::LENGTH_WIDTH-1:0]  csr_write_data,
   input  wire logic [ded_pkg::ELEMENT_WIDTH-1:0] first_element,
   input  wire logic [ded_pkg::ELEMENT_WIDTH-1:0] second_element,
   input  wire ded_pkg::ded_cmd_type              cmd,
   output      ded_pkg::ded_status_type           status,
   output      logic [ded_pkg::DIST_WIDTH-1:0]    distance,
   output      logic [ded_pkg::SUM_WIDTH-1:0]     squared_sum
);

   logic [ded_pkg::LENGTH_WIDTH-1:0]  vector_length_ff;
   logic [ded_pkg::LENGTH_WIDTH-1:0]  count_ff;
   logic [ded_pkg::LENGTH_WIDTH-1:0]  count_plus;
   logic [ded_pkg::LENGTH_WIDTH-1:0]  eff_length;
   logic [ded_pkg::ELEMENT_WIDTH-1:0] diff;
   logic [ded_pkg::SQUARE_WIDTH-1:0]  square_ff;
   logic [ded_pkg::SUM_WIDTH-1:0]     sum_ff;
   logic [ded_pkg::SUM_WIDTH:0]       sum_wide;
   logic [ded_pkg::SUM_WIDTH-1:0]     sum_sat;
   logic [ded_pkg::SUM_WIDTH-1:0]     snap_ff;
   logic [ded_pkg::RAD_WIDTH-1:0]     rad_ff;
   logic [ded_pkg::REM_WIDTH-1:0]     rem_ff;
   logic [ded_pkg::REM_WIDTH-1:0]     rem_shift;
   logic [ded_pkg::REM_WIDTH-1:0]     trial;
   logic [ded_pkg::DIST_WIDTH-1:0]    root_ff;
   logic [ded_pkg::DIST_WIDTH-1:0]    distance_ff;
   logic [ded_pkg::SUM_WIDTH-1:0]     squared_sum_ff;

   // A length of zero behaves as one, and anything above the maximum is clipped.
   always_comb begin
      if (vector_length_ff == '0) begin
         eff_length = ded_pkg::LENGTH_WIDTH'(1);
      end else if (vector_length_ff > ded_pkg::LENGTH_WIDTH'(ded_pkg::MAX_LENGTH)) begin
         eff_length = ded_pkg::LENGTH_WIDTH'(ded_pkg::MAX_LENGTH);
      end else begin
         eff_length = vector_length_ff;
      end
   end

   assign count_plus  = count_ff + ded_pkg::LENGTH_WIDTH'(1);
   assign status.last = (count_plus >= eff_length);

   assign diff = (first_element >= second_element) ? (first_element - second_element)
                                                   : (second_element - first_element);

   assign sum_wide = {1'b0, sum_ff}
                   + {{(ded_pkg::SUM_WIDTH + 1 - ded_pkg::SQUARE_WIDTH){1'b0}}, square_ff};
   assign sum_sat  = sum_wide[ded_pkg::SUM_WIDTH] ? '1 : sum_wide[ded_pkg::SUM_WIDTH-1:0];

   assign rem_shift = {rem_ff[ded_pkg::REM_WIDTH-3:0],
                       rad_ff[ded_pkg::RAD_WIDTH-1:ded_pkg::RAD_WIDTH-2]};
   assign trial     = {1'b0, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         vector_length_ff <= ded_pkg::LENGTH_WIDTH'(ded_pkg::LENGTH_RESET);
         count_ff         <= '0;
         sum_ff           <= '0;
      end else begin
         if (csr_write_enable) begin
            vector_length_ff <= csr_write_data;
         end
         if (cmd.capture) begin
            count_ff <= status.last ? '0 : count_plus;
         end
         if (cmd.accumulate) begin
            sum_ff <= cmd.start ? '0 : sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         square_ff <= ded_pkg::SQUARE_WIDTH'(diff) * ded_pkg::SQUARE_WIDTH'(diff);
      end
      if (cmd.accumulate && cmd.start) begin
         snap_ff <= sum_sat;
         rad_ff  <= {{(ded_pkg::RAD_WIDTH - ded_pkg::SUM_WIDTH){1'b0}}, sum_sat};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.iterate) begin
         rad_ff <= {rad_ff[ded_pkg::RAD_WIDTH-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_ff  <= rem_shift - trial;
            root_ff <= {root_ff[ded_pkg::DIST_WIDTH-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_shift;
            root_ff <= {root_ff[ded_pkg::DIST_WIDTH-2:0], 1'b0};
         end
      end
      if (cmd.publish) begin
         distance_ff    <= root_ff;
         squared_sum_ff <= snap_ff;
      end
   end

   assign distance    = distance_ff;
   assign squared_sum = squared_sum_ff;

endmodule

`default_nettype wire

### design/ded_ctrl.sv
// ----------------------------------------------------------------------------
// ded_ctrl
// Sequencer: input handshake, accumulate pipeline control, square root
// iteration count and the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ded_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire ded_pkg::ded_status_type status,
   output      ded_pkg::ded_cmd_type    cmd
);

   ded_pkg::ded_state_type           state_ff;
   ded_pkg::ded_state_type           state_in;
   logic [ded_pkg::ITER_WIDTH-1:0]   iter_ff;
   logic [ded_pkg::ITER_WIDTH-1:0]   iter_in;
   logic                             acc_ff;
   logic                             start_ff;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic                             accept;
   logic                             iter_last;

   // Only a transaction that closes a descriptor waits for the root unit.
   assign req_ready = !(status.last && (start_ff || (state_ff != ded_pkg::ST_ACCUM)));
   assign accept    = req_valid && req_ready;
   assign iter_last = (iter_ff == ded_pkg::ITER_WIDTH'(ded_pkg::ROOT_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ded_pkg::ST_ACCUM: begin
            if (start_ff) begin
               state_in = ded_pkg::ST_ROOT;
            end
         end
         ded_pkg::ST_ROOT: begin
            if (iter_last) begin
               state_in = ded_pkg::ST_HOLD;
            end
         end
         ded_pkg::ST_HOLD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ded_pkg::ST_ACCUM;
            end
         end
         default: begin
            state_in = ded_pkg::ST_ACCUM;
         end
      endcase
   end

   always_comb begin
      cmd.capture    = accept;
      cmd.accumulate = acc_ff;
      cmd.start      = start_ff;
      cmd.iterate    = (state_ff == ded_pkg::ST_ROOT);
      cmd.publish    = (state_ff == ded_pkg::ST_HOLD) && (!rsp_valid_ff || rsp_ready);
      iter_in        = (state_ff == ded_pkg::ST_ROOT) ? iter_ff + ded_pkg::ITER_WIDTH'(1) : '0;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ded_pkg::ST_ACCUM;
         iter_ff      <= '0;
         acc_ff       <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         acc_ff       <= accept;
         start_ff     <= accept && status.last;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> (state_ff == ded_pkg::ST_ACCUM))
      else $error("Root unit started while still busy.");

   a_last_starts_root: assert property (@(posedge clock) disable iff (reset)
      (accept && status.last) |=> (start_ff && acc_ff))
      else $error("Closing transaction did not start the root unit.");

   a_root_length: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ded_pkg::ST_ROOT) && iter_last) |=> (state_ff == ded_pkg::ST_HOLD))
      else $error("Root iteration count is wrong.");

   a_result_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ded_pkg::ST_HOLD))
      else $error("Result presented without a finished root.");

endmodule

`default_nettype wire
